// ===== design/autoscaled_history_trace_unit_assert.svh =====
// Assertion macros used by the checker file of the trace unit.
`ifndef AUTOSCALED_HISTORY_TRACE_UNIT_ASSERT_SVH
`define AUTOSCALED_HISTORY_TRACE_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define AHTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked while the reset is asserted.
`define AHTU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/ahtu_pkg.sv =====
`default_nettype none
package ahtu_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned WIN_W = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;
  localparam int unsigned SMP_W = 32;
  localparam int unsigned ST_W = 2;
  localparam int unsigned PT_W = 16;

  localparam int unsigned RW = 54;
  localparam int unsigned DW = 38;
  localparam int unsigned QW = 16;
  localparam int unsigned KW = 4;

  localparam logic [21:0] Y_SCALE = 22'd2752534;
  localparam logic [21:0] Y_STEP = 22'd2621440;
  localparam logic [5:0] Y_DEN = 6'd44;
  localparam logic [17:0] X_NUM = 18'd131070;
  localparam logic [PT_W-1:0] FLAT_Y = 16'd32768;

  typedef struct packed {
    logic accept;
    logic load_empty;
    logic scan_init;
    logic scan_step;
    logic span_calc;
    logic setup;
    logic div_step;
    logic xset;
    logic pt_diff;
    logic pt_load;
    logic load_point;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic scan_last;
    logic div_last;
    logic flat;
    logic out_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/ahtu_in_if.sv =====
`default_nettype none
interface ahtu_in_if import ahtu_pkg::*; ();
  logic valid;
  logic ready;
  logic has_sample;
  logic signed [SMP_W-1:0] sample_value;
  logic [ST_W-1:0] reading_state;

  modport source(output valid, has_sample, sample_value, reading_state, input ready);
  modport sink(input valid, has_sample, sample_value, reading_state, output ready);
endinterface
`default_nettype wire

// ===== design/ahtu_out_if.sv =====
`default_nettype none
interface ahtu_out_if import ahtu_pkg::*; ();
  logic valid;
  logic ready;
  logic trace_empty;
  logic [PT_W-1:0] point_x;
  logic [PT_W-1:0] point_y;
  logic last_point;
  logic [ST_W-1:0] state_out;

  modport source(output valid, trace_empty, point_x, point_y, last_point, state_out,
                 input ready);
  modport sink(input valid, trace_empty, point_x, point_y, last_point, state_out,
               output ready);
endinterface
`default_nettype wire

// ===== design/autoscaled_history_trace_unit.sv =====
// Autoscaled history trace: each reading transfer is taken only while the unit is idle, appends
// its sample to the window when it carries one, and then redraws the trace as one result
// transfer per held sample (or a single empty-trace result when fewer than two are held). A
// redraw is paced by the 16-step shared divider, used once for the horizontal step and once per
// point for the vertical position (skipped when all samples are equal), by the window scan
// through the registered sample memory, and by any output stall.
`default_nettype none
module autoscaled_history_trace_unit import ahtu_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ahtu_in_if.sink in_i,
  ahtu_out_if.source out_o,
  input  logic cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  ahtu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ahtu_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .has_sample_i    (in_i.has_sample),
    .sample_value_i  (in_i.sample_value),
    .reading_state_i (in_i.reading_state),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .trace_empty_o   (out_o.trace_empty),
    .point_x_o       (out_o.point_x),
    .point_y_o       (out_o.point_y),
    .last_point_o    (out_o.last_point),
    .state_out_o     (out_o.state_out)
  );

endmodule
`default_nettype wire

// ===== design/ahtu_ctrl.sv =====
`default_nettype none
module ahtu_ctrl import ahtu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_SPAN = 4'd4;
  localparam logic [3:0] S_SETUP = 4'd5;
  localparam logic [3:0] S_XDIV = 4'd6;
  localparam logic [3:0] S_XSET = 4'd7;
  localparam logic [3:0] S_PRD  = 4'd8;
  localparam logic [3:0] S_PDIF = 4'd9;
  localparam logic [3:0] S_PLD  = 4'd10;
  localparam logic [3:0] S_PDIV = 4'd11;
  localparam logic [3:0] S_PPT  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (sts_i.few) begin
          cmd_o.load_empty = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = S_SRD;
        end
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        cmd_o.scan_step = 1'b1;
        state_d = sts_i.scan_last ? S_SPAN : S_SRD;
      end
      S_SPAN: begin
        cmd_o.span_calc = 1'b1;
        state_d = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = S_XDIV;
      end
      S_XDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_XSET;
        end
      end
      S_XSET: begin
        cmd_o.xset = 1'b1;
        state_d = S_PRD;
      end
      S_PRD: state_d = S_PDIF;
      S_PDIF: begin
        cmd_o.pt_diff = 1'b1;
        state_d = sts_i.flat ? S_PPT : S_PLD;
      end
      S_PLD: begin
        cmd_o.pt_load = 1'b1;
        state_d = S_PDIV;
      end
      S_PDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_PPT;
        end
      end
      S_PPT: begin
        cmd_o.load_point = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = sts_i.out_last ? S_IDLE : S_PRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ahtu_dpath.sv =====
`default_nettype none
module ahtu_dpath import ahtu_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i,
  input  logic has_sample_i,
  input  logic signed [SMP_W-1:0] sample_value_i,
  input  logic [ST_W-1:0] reading_state_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic trace_empty_o,
  output logic [PT_W-1:0] point_x_o,
  output logic [PT_W-1:0] point_y_o,
  output logic last_point_o,
  output logic [ST_W-1:0] state_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned XW = FW + 1;

  logic signed [SMP_W-1:0] mem [DEPTH];
  logic signed [SMP_W-1:0] rd_data_q;

  logic [AW-1:0] wp_q, rd_ptr_q;
  logic [FW-1:0] fill_q, cnt_q;
  logic [WIN_W-1:0] win_q;
  logic signed [SMP_W-1:0] lo_q, hi_q;
  logic [SMP_W-1:0] span_q, diff_q;
  logic [RW-1:0] ks_q, rem_q, dsh_q;
  logic [DW-1:0] den44_q;
  logic [QW-1:0] quo_q;
  logic [KW-1:0] k_q;
  logic [PT_W-1:0] xa_q, xq_q;
  logic [XW-1:0] xb_q, xr_q;
  logic [ST_W-1:0] st_q;
  logic empty_q, last_q;
  logic [PT_W-1:0] px_q, py_q;

  logic [FW-1:0] eff_cur, eff_new, nm1;
  logic [XW-1:0] xden, base_w;
  logic [AW-1:0] base, rd_nxt, wp_nxt;
  logic [XW:0] xsum;
  logic signed [SMP_W:0] vdiff, sdiff;
  logic [RW-1:0] num_y;
  logic div_ge;

  function automatic logic [FW-1:0] eff_win(input logic [WIN_W-1:0] w);
    logic [FW-1:0] r;
    if (w == '0) begin
      r = FW'(1);
    end else if (32'(w) > DEPTH) begin
      r = FW'(DEPTH);
    end else begin
      r = FW'(w);
    end
    return r;
  endfunction

  assign eff_cur = eff_win(win_q);
  assign eff_new = eff_win(cfg_wdata_i);
  assign nm1 = fill_q - FW'(1);
  assign xden = {nm1, 1'b0};
  assign base_w = (XW'(wp_q) >= XW'(fill_q)) ? XW'(wp_q) - XW'(fill_q)
                                             : XW'(wp_q) + XW'(DEPTH) - XW'(fill_q);
  assign base = base_w[AW-1:0];
  assign rd_nxt = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wp_nxt = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign xsum = (XW + 1)'(xr_q) + (XW + 1)'(xb_q);
  assign vdiff = (SMP_W + 1)'(rd_data_q) - (SMP_W + 1)'(lo_q);
  assign sdiff = (SMP_W + 1)'(hi_q) - (SMP_W + 1)'(lo_q);
  assign num_y = ks_q - RW'(diff_q) * RW'(Y_STEP);
  assign div_ge = rem_q >= dsh_q;

  assign sts_o.few = fill_q < FW'(2);
  assign sts_o.scan_last = cnt_q == nm1;
  assign sts_o.div_last = k_q == '0;
  assign sts_o.flat = span_q == '0;
  assign sts_o.out_last = last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && has_sample_i) begin
      mem[wp_q] <= sample_value_i;
    end
    rd_data_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      fill_q <= '0;
      win_q <= WIN_RESET;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
        if (fill_q > eff_new) begin
          fill_q <= eff_new;
        end
      end else if (cmd_i.accept && has_sample_i) begin
        wp_q <= wp_nxt;
        fill_q <= (fill_q < eff_cur) ? fill_q + FW'(1) : eff_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      st_q <= reading_state_i;
    end
    if (cmd_i.scan_init) begin
      rd_ptr_q <= base;
      cnt_q <= '0;
    end
    if (cmd_i.scan_step) begin
      if (cnt_q == '0) begin
        lo_q <= rd_data_q;
        hi_q <= rd_data_q;
      end else begin
        if (rd_data_q < lo_q) lo_q <= rd_data_q;
        if (rd_data_q > hi_q) hi_q <= rd_data_q;
      end
      cnt_q <= cnt_q + FW'(1);
      rd_ptr_q <= rd_nxt;
    end
    if (cmd_i.span_calc) begin
      span_q <= sdiff[SMP_W-1:0];
    end
    if (cmd_i.setup) begin
      ks_q <= RW'(span_q) * RW'(Y_SCALE);
      den44_q <= DW'(span_q) * DW'(Y_DEN);
      rem_q <= RW'(X_NUM);
      dsh_q <= RW'(xden) << (QW - 1);
      quo_q <= '0;
      k_q <= KW'(QW - 1);
    end
    if (cmd_i.pt_load) begin
      rem_q <= num_y;
      dsh_q <= RW'(den44_q) << (QW - 1);
      quo_q <= '0;
      k_q <= KW'(QW - 1);
    end
    if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QW-2:0], div_ge};
      dsh_q <= dsh_q >> 1;
      k_q <= k_q - 1'b1;
    end
    if (cmd_i.xset) begin
      xa_q <= quo_q;
      xb_q <= rem_q[XW-1:0];
      xq_q <= '0;
      xr_q <= XW'(nm1);
      cnt_q <= '0;
      rd_ptr_q <= base;
    end
    if (cmd_i.pt_diff) begin
      diff_q <= vdiff[SMP_W-1:0];
    end
    if (cmd_i.load_empty) begin
      empty_q <= 1'b1;
      px_q <= '0;
      py_q <= '0;
      last_q <= 1'b1;
    end
    if (cmd_i.load_point) begin
      empty_q <= 1'b0;
      px_q <= xq_q;
      py_q <= (span_q == '0) ? FLAT_Y : quo_q;
      last_q <= cnt_q == nm1;
      cnt_q <= cnt_q + FW'(1);
      rd_ptr_q <= rd_nxt;
      if (xsum >= (XW + 1)'(xden)) begin
        xq_q <= xq_q + xa_q + 1'b1;
        xr_q <= XW'(xsum - (XW + 1)'(xden));
      end else begin
        xq_q <= xq_q + xa_q;
        xr_q <= XW'(xsum);
      end
    end
  end

  assign trace_empty_o = empty_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign last_point_o = last_q;
  assign state_out_o = st_q;

endmodule
`default_nettype wire

// ===== design/ahtu_checker.sv =====
`default_nettype none
`include "autoscaled_history_trace_unit_assert.svh"
module ahtu_checker import ahtu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic trace_empty_i,
  input logic [PT_W-1:0] point_x_i,
  input logic [PT_W-1:0] point_y_i,
  input logic last_point_i
);

  `AHTU_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_i, "result offered during reset")
  `AHTU_ASSERT(a_one_side, !(in_ready_i && out_valid_i), "input taken while a result waits")
  `AHTU_ASSERT(a_empty_form, out_valid_i && trace_empty_i |-> last_point_i && point_x_i == '0 && point_y_i == '0, "malformed empty trace")
  `AHTU_ASSERT(a_last_frees, out_valid_i && out_ready_i && last_point_i |=> in_ready_i, "not ready after final transfer")
  `AHTU_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(point_x_i) && $stable(point_y_i), "stalled result changed")

endmodule

bind autoscaled_history_trace_unit ahtu_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .trace_empty_i (out_o.trace_empty),
  .point_x_i     (out_o.point_x),
  .point_y_i     (out_o.point_y),
  .last_point_i  (out_o.last_point)
);
`default_nettype wire
